// ===== design/furs_pkg.sv =====
`default_nettype none
// ============================================================================
// furs_pkg
// Shared types and constants of the framed receiver with frame slots.
// ============================================================================
package furs_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_READ    = 2'd2,
        KIND_RELEASE = 2'd3
    } furs_kind_t;

    localparam int SLOTS     = 4;
    localparam int FRAME_MAX = 16;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W     = $clog2(FRAME_MAX + 1);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ADDR_W    = $clog2(SLOTS * FRAME_MAX);

    localparam logic [7:0] CFG_HEADER  = 8'd0;
    localparam logic [7:0] CFG_TIMEOUT = 8'd1;

    localparam logic [7:0] HEADER_RST  = 8'hA5;
    localparam logic [7:0] TIMEOUT_RST = 8'd10;
    localparam logic [7:0] TICK_MAX    = 8'hFF;

    // first member sits in the top bits
    typedef struct packed {
        logic       overlength;
        logic       timed_out;
        logic [2:0] frames_held;
        logic       slot_ready;
        logic [7:0] read_data;
        logic [4:0] frame_length;
        logic [1:0] frame_slot;
        logic       frame_ok;
        logic       frame_done;
    } furs_result_t;

endpackage
`default_nettype wire

// ===== design/furs_store.sv =====
`default_nettype none
// ============================================================================
// furs_store
// Frame byte memory: one write port, one read port with registered data.
// ============================================================================
module furs_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/furs_ctrl.sv =====
`default_nettype none
// ============================================================================
// furs_ctrl
// Frame reception, checksum, timeout and slot table; issues store accesses.
// ============================================================================
module furs_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire furs_pkg::furs_kind_t        kind,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic [1:0]                  slot,
    input  wire logic [3:0]                  offset,
    input  wire logic [7:0]                  header_byte,
    input  wire logic [7:0]                  timeout_limit,
    output furs_pkg::furs_result_t           res,
    output logic                             rd_ok,
    output logic                             wr_en,
    output logic [furs_pkg::ADDR_W-1:0]      wr_addr,
    output logic [7:0]                       wr_data,
    output logic                             rd_en,
    output logic [furs_pkg::ADDR_W-1:0]      rd_addr
);
    import furs_pkg::*;

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic              rcv_reg, rcv_next;
    logic [7:0]        exp_len_reg, exp_len_next;
    logic [POS_W-1:0]  bsf_reg, bsf_next;
    logic [7:0]        sum_reg, sum_next;
    logic              armed_reg, armed_next;
    logic [7:0]        tcount_reg, tcount_next;
    logic [SLOTS-1:0]  full_reg, full_next;
    logic [POS_W-1:0]  len_reg [SLOTS];
    logic [POS_W-1:0]  len_next [SLOTS];

    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pos1;
    logic              go;
    logic              in_range;
    logic [SLOT_W-1:0] sidx;
    logic [POS_W-1:0]  rlen;
    logic [7:0]        tc;

    always_comb
    begin
        write_slot_next = write_slot_reg;
        held_next       = held_reg;
        rcv_next        = rcv_reg;
        exp_len_next    = exp_len_reg;
        bsf_next        = bsf_reg;
        sum_next        = sum_reg;
        armed_next      = armed_reg;
        tcount_next     = tcount_reg;
        full_next       = full_reg;
        len_next        = len_reg;
        res             = '0;
        rd_ok           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = rx_byte;
        rd_en           = 1'b0;
        pos             = bsf_reg;
        pos1            = bsf_reg;
        go              = 1'b0;
        in_range        = int'(slot) < SLOTS;
        sidx            = SLOT_W'(slot);
        rlen            = '0;
        tc              = tcount_reg;
        wr_addr         = ADDR_W'(int'(write_slot_reg) * FRAME_MAX + int'(bsf_reg));
        rd_addr         = ADDR_W'(int'(sidx) * FRAME_MAX + int'(offset));

        unique case (kind)
            KIND_BYTE:
            begin
                if ((!rcv_reg && rx_byte != header_byte) || int'(held_reg) >= SLOTS)
                begin
                    armed_next  = 1'b0;
                    tcount_next = '0;
                end
                else
                begin
                    go = 1'b1;
                    if (rx_byte == header_byte)
                    begin
                        rcv_next     = 1'b1;
                        exp_len_next = '0;
                        bsf_next     = '0;
                        sum_next     = '0;
                        armed_next   = 1'b1;
                        tcount_next  = '0;
                    end
                    pos     = bsf_next;
                    wr_addr = ADDR_W'(int'(write_slot_reg) * FRAME_MAX + int'(pos));
                    if (int'(pos) == 1)
                    begin
                        exp_len_next = rx_byte;
                        if (int'(rx_byte) > FRAME_MAX || rx_byte < 8'd2)
                        begin
                            res.overlength = int'(rx_byte) > FRAME_MAX;
                            go = 1'b0;
                        end
                    end
                    if (go && full_reg[write_slot_reg])
                    begin
                        go = 1'b0;
                    end
                    else if (go && int'(pos) >= FRAME_MAX)
                    begin
                        go = 1'b0;
                        res.overlength = 1'b0;
                    end
                    if (!go && !full_reg[write_slot_reg])
                    begin
                        rcv_next     = 1'b0;
                        exp_len_next = '0;
                        bsf_next     = '0;
                        sum_next     = '0;
                        armed_next   = 1'b0;
                        tcount_next  = '0;
                    end
                    else if (!go && res.overlength)
                    begin
                        rcv_next     = 1'b0;
                        exp_len_next = '0;
                        bsf_next     = '0;
                        sum_next     = '0;
                        armed_next   = 1'b0;
                        tcount_next  = '0;
                    end
                    else if (!go && int'(pos) == 1 && rx_byte < 8'd2)
                    begin
                        rcv_next     = 1'b0;
                        exp_len_next = '0;
                        bsf_next     = '0;
                        sum_next     = '0;
                        armed_next   = 1'b0;
                        tcount_next  = '0;
                    end
                    if (go)
                    begin
                        wr_en       = 1'b1;
                        pos1        = pos + POS_W'(1);
                        bsf_next    = pos1;
                        tcount_next = '0;
                        if (exp_len_next != 8'd0 && 8'(pos1) == exp_len_next)
                        begin
                            res.frame_done   = 1'b1;
                            res.frame_ok     = sum_next == rx_byte;
                            res.frame_slot   = 2'(write_slot_reg);
                            res.frame_length = exp_len_next[4:0];
                            if (sum_next == rx_byte)
                            begin
                                full_next[write_slot_reg] = 1'b1;
                                len_next[write_slot_reg]  = POS_W'(exp_len_next);
                                held_next = held_reg + CNT_W'(1);
                                if (int'(write_slot_reg) == SLOTS - 1)
                                begin
                                    write_slot_next = '0;
                                end
                                else
                                begin
                                    write_slot_next = write_slot_reg + SLOT_W'(1);
                                end
                            end
                            rcv_next     = 1'b0;
                            exp_len_next = '0;
                            bsf_next     = '0;
                            sum_next     = '0;
                            armed_next   = 1'b0;
                            tcount_next  = '0;
                        end
                        else
                        begin
                            sum_next = sum_next + rx_byte;
                        end
                    end
                end
            end
            KIND_TICK:
            begin
                if (armed_reg)
                begin
                    if (tcount_reg != TICK_MAX)
                    begin
                        tc = tcount_reg + 8'd1;
                    end
                    tcount_next = tc;
                    if (tc > timeout_limit)
                    begin
                        rcv_next      = 1'b0;
                        exp_len_next  = '0;
                        bsf_next      = '0;
                        sum_next      = '0;
                        armed_next    = 1'b0;
                        tcount_next   = '0;
                        res.timed_out = 1'b1;
                    end
                end
            end
            KIND_READ:
            begin
                if (in_range)
                begin
                    rlen             = len_reg[sidx];
                    res.frame_length = 5'(rlen);
                    res.slot_ready   = full_reg[sidx];
                    rd_ok = full_reg[sidx] && int'(offset) < int'(rlen)
                            && int'(offset) < FRAME_MAX;
                    rd_en = take && rd_ok;
                end
            end
            KIND_RELEASE:
            begin
                if (in_range && full_reg[sidx])
                begin
                    full_next[sidx] = 1'b0;
                    len_next[sidx]  = '0;
                    if (held_reg != '0)
                    begin
                        held_next = held_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.frames_held = 3'(held_next);
        wr_en = wr_en && take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            held_reg       <= '0;
            rcv_reg        <= 1'b0;
            exp_len_reg    <= '0;
            bsf_reg        <= '0;
            sum_reg        <= '0;
            armed_reg      <= 1'b0;
            tcount_reg     <= '0;
            full_reg       <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            write_slot_reg <= write_slot_next;
            held_reg       <= held_next;
            rcv_reg        <= rcv_next;
            exp_len_reg    <= exp_len_next;
            bsf_reg        <= bsf_next;
            sum_reg        <= sum_next;
            armed_reg      <= armed_next;
            tcount_reg     <= tcount_next;
            full_reg       <= full_next;
            len_reg        <= len_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/framed_uart_receiver_slots_unit.sv =====
`default_nettype none
// ============================================================================
// framed_uart_receiver_slots_unit
// Framed byte receiver storing checksummed frames into a ring of slots.
// ============================================================================
// Bytes, ticks and releases pass straight to the result register, so they
// stream at one request per clock while the sink keeps up; a read waits for
// the registered read port of the frame memory, and no request is taken until
// its result is written. One result register sits on the output: a request is
// taken only when it is empty or its result leaves in the same cycle. The slot
// count and slot size are fixed in the package. The frame memory needs no clear
// after reset: a byte is only returned from a slot whose frame was written.
module framed_uart_receiver_slots_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // rx_byte, slot, offset, zero pad
    input  wire logic [1:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // frame_done, frame_ok, frame_slot, frame_length, read_data, slot_ready,
    // frames_held, timed_out, overlength, zero pad
    output logic      [23:0] m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import furs_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t       state_reg, state_next;
    logic [7:0]   header_reg;
    logic [7:0]   timeout_reg;
    furs_result_t out_reg, out_next;
    logic         out_valid_reg, out_valid_next;
    furs_result_t pend_reg, pend_next;
    logic         pend_ok_reg, pend_ok_next;

    furs_kind_t        kind;
    logic              take;
    furs_result_t      res;
    logic              rd_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign kind      = furs_kind_t'(s_tuser);
    assign s_tready  = (state_reg == ST_RUN) && (!out_valid_reg || m_tready);
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_reg};

    furs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .kind          (kind),
        .rx_byte       (s_tdata[7:0]),
        .slot          (s_tdata[9:8]),
        .offset        (s_tdata[13:10]),
        .header_byte   (header_reg),
        .timeout_limit (timeout_reg),
        .res           (res),
        .rd_ok         (rd_ok),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr)
    );

    furs_store #(
        .DEPTH  (SLOTS * FRAME_MAX),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pend_next      = pend_reg;
        pend_ok_next   = pend_ok_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (take)
                begin
                    if (kind == KIND_READ)
                    begin
                        state_next   = ST_READ;
                        pend_next    = res;
                        pend_ok_next = rd_ok;
                    end
                    else
                    begin
                        out_next       = res;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                out_next           = pend_reg;
                out_next.read_data = pend_ok_reg ? rd_data : 8'd0;
                out_valid_next     = 1'b1;
                state_next         = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
            header_reg    <= HEADER_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HEADER:  header_reg  <= cfg_data;
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        pend_reg    <= pend_next;
        pend_ok_reg <= pend_ok_next;
    end

    a_read_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !out_valid_reg)
        else $error("read completion would overwrite a waiting result");

    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        take && kind == KIND_READ |-> ##2 out_valid_reg)
        else $error("read request did not produce a result");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.frame_ok |-> out_reg.frame_done)
        else $error("frame_ok without frame_done");

    a_data_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.read_data != 8'd0 |-> out_reg.slot_ready)
        else $error("read data returned from a slot without a frame");

endmodule
`default_nettype wire

// ===== tb/framed_uart_receiver_slots_unit_test.sv =====
// ============================================================================
// framed_uart_receiver_slots_unit_test
// Self-checking bench for the framed byte receiver with a ring of frame slots.
// Requests stream in with bursts and gaps, and results drain past a stalling
// sink. A predictor tracks the slot ring, the frame parser and the tick
// timeout, and checks every result field against it. The run steps through
// header and timeout settings that include the extremes.
// ============================================================================
module framed_uart_receiver_slots_unit_test;
    import furs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] STALL_PAT = 8'b1101_0110;

    typedef struct {
        furs_kind_t kind;
        logic [7:0] rx;
        logic [1:0] slot;
        logic [3:0] off;
        bit         drain;
    } rx_request_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    framed_uart_receiver_slots_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver model state
    logic [7:0] frame_bytes [SLOTS*FRAME_MAX];
    logic [4:0] slot_len    [SLOTS] = '{default: '0};
    logic       slot_held   [SLOTS] = '{default: 1'b0};
    logic [1:0] wr_slot     = '0;
    logic [2:0] held        = '0;
    logic       in_frame    = 1'b0;
    logic [7:0] want_len    = '0;
    logic [4:0] frame_fill  = '0;
    logic [7:0] csum        = '0;
    logic       tick_armed  = 1'b0;
    logic [7:0] tick_count  = '0;
    logic [7:0] hdr_value   = HEADER_RST;
    logic [7:0] tmo_limit   = TIMEOUT_RST;

    rx_request_t  req_q[$];
    furs_result_t frame_result_q[$];

    int total_queued, accepted, results_seen, fail_count;
    int n_good, n_bad, n_timeout, n_overlen, n_read_hits, n_full_drops;
    int burst_left = 8, gap_left = 0;
    int hold_left = 0, stall_mode = 0, cycle_cnt = 0;
    furs_result_t seen, want;

    function automatic void abandon_frame();
        in_frame   = 1'b0;
        want_len   = '0;
        frame_fill = '0;
        csum       = '0;
        tick_armed = 1'b0;
        tick_count = '0;
    endfunction

    function automatic furs_result_t frame_step(input rx_request_t r);
        furs_result_t o;
        logic [1:0]   ws;
        logic [4:0]   pos;
        logic [4:0]   len;
        bit           stop;
        o    = '0;
        ws   = wr_slot;
        stop = 1'b0;
        case (r.kind)
            KIND_BYTE:
            begin
                if ((!in_frame && r.rx != hdr_value) || held >= SLOTS)
                begin
                    if (held >= SLOTS)
                        n_full_drops++;
                    tick_armed = 1'b0;
                    tick_count = '0;
                    stop = 1'b1;
                end
                if (!stop && r.rx == hdr_value)
                begin
                    abandon_frame();
                    in_frame   = 1'b1;
                    tick_armed = 1'b1;
                end
                pos = frame_fill;
                if (!stop && pos == 1)
                begin
                    want_len = r.rx;
                    if (r.rx > FRAME_MAX)
                    begin
                        abandon_frame();
                        o.overlength = 1'b1;
                        n_overlen++;
                        stop = 1'b1;
                    end
                    else if (r.rx < 2)
                    begin
                        abandon_frame();
                        stop = 1'b1;
                    end
                end
                if (!stop && slot_held[ws])
                    stop = 1'b1;
                if (!stop && pos >= FRAME_MAX)
                begin
                    abandon_frame();
                    stop = 1'b1;
                end
                if (!stop)
                begin
                    frame_bytes[{ws, pos[3:0]}] = r.rx;
                    frame_fill = pos + 5'd1;
                    tick_count = '0;
                    if (want_len != 0 && frame_fill == want_len)
                    begin
                        o.frame_done   = 1'b1;
                        o.frame_ok     = (csum == r.rx);
                        o.frame_slot   = ws;
                        o.frame_length = want_len[4:0];
                        if (csum == r.rx)
                        begin
                            slot_held[ws] = 1'b1;
                            slot_len[ws]  = want_len[4:0];
                            held++;
                            wr_slot = ws + 2'd1;
                            n_good++;
                        end
                        else
                            n_bad++;
                        abandon_frame();
                    end
                    else
                        csum = csum + r.rx;
                end
            end
            KIND_TICK:
            begin
                if (tick_armed)
                begin
                    if (tick_count < TICK_MAX)
                        tick_count++;
                    if (tick_count > tmo_limit)
                    begin
                        abandon_frame();
                        o.timed_out = 1'b1;
                        n_timeout++;
                    end
                end
            end
            KIND_READ:
            begin
                len = slot_len[r.slot];
                o.frame_length = len;
                if (slot_held[r.slot])
                begin
                    o.slot_ready = 1'b1;
                    if (r.off < len)
                    begin
                        o.read_data = frame_bytes[{r.slot, r.off}];
                        n_read_hits++;
                    end
                end
            end
            default:
            begin
                if (slot_held[r.slot])
                begin
                    slot_held[r.slot] = 1'b0;
                    slot_len[r.slot]  = '0;
                    if (held > 0)
                        held--;
                end
            end
        endcase
        o.frames_held = held;
        return o;
    endfunction

    function automatic string show_result(input furs_result_t r);
        return {$sformatf("done=%0d ok=%0d slot=%0d len=%0d data=%02h ",
                          r.frame_done, r.frame_ok, r.frame_slot, r.frame_length,
                          r.read_data),
                $sformatf("rdy=%0d held=%0d tmo=%0d ovl=%0d",
                          r.slot_ready, r.frames_held, r.timed_out, r.overlength)};
    endfunction

    task automatic log_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                frame_result_q.push_back(frame_step(req_q.pop_front()));
                accepted++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (req_q.size() == 0 || (req_q[0].drain && frame_result_q.size() != 0))
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= req_q[0].kind;
                    s_tdata  <= {2'b00, req_q[0].off, req_q[0].slot, req_q[0].rx};
                end
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            cycle_cnt++;
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata[22:0];
                results_seen++;
                if (frame_result_q.size() == 0)
                    log_fail({"unexpected result ", show_result(seen)});
                else
                begin
                    want = frame_result_q.pop_front();
                    if (seen.frame_done !== want.frame_done || seen.frame_ok !== want.frame_ok
                        || seen.frame_slot !== want.frame_slot
                        || seen.frame_length !== want.frame_length
                        || seen.read_data !== want.read_data
                        || seen.slot_ready !== want.slot_ready
                        || seen.frames_held !== want.frames_held
                        || seen.timed_out !== want.timed_out
                        || seen.overlength !== want.overlength)
                        log_fail({"expected ", show_result(want), " got ", show_result(seen)});
                end
                if (results_seen % 200 == 90)
                    hold_left = $urandom_range(60, 100);
                if (results_seen % 37 == 0)
                    stall_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= STALL_PAT[cycle_cnt[2:0]];
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic push_req(input furs_kind_t k, input logic [7:0] b, input logic [1:0] s,
                            input logic [3:0] o, input bit d);
        rx_request_t r;
        r.kind  = k;
        r.rx    = b;
        r.slot  = s;
        r.off   = o;
        r.drain = d;
        req_q.push_back(r);
        total_queued++;
    endtask

    task automatic push_rand(input furs_kind_t k);
        push_req(k, 8'($urandom), 2'($urandom), 4'($urandom), 1'b0);
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_req(KIND_BYTE, b, 2'($urandom), 4'($urandom), 1'b0);
    endtask

    task automatic push_frame(input int len, input bit corrupt, input bit d);
        logic [7:0] body [FRAME_MAX];
        logic [7:0] sum;
        int         i;
        int         tries;
        tries = 0;
        do
        begin
            body[0] = hdr_value;
            body[1] = len[7:0];
            sum = hdr_value + len[7:0];
            for (i = 2; i < len - 1; i++)
            begin
                do
                    body[i] = 8'($urandom);
                while (body[i] == hdr_value);
                sum = sum + body[i];
            end
            if (len > 2)
                body[len-1] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
            tries++;
        end
        while (len > 2 && body[len-1] == hdr_value && tries < 8);
        for (i = 0; i < len; i++)
        begin
            push_req(KIND_BYTE, body[i], 2'($urandom), 4'($urandom), d && i == 0);
            if (i < len - 1 && $urandom_range(0, 99) < 10)
            begin
                if ($urandom_range(0, 1) == 1)
                    push_rand(KIND_READ);
                else if (tmo_limit != 0)
                    repeat ($urandom_range(1, tmo_limit < 4 ? tmo_limit : 4))
                        push_rand(KIND_TICK);
            end
        end
    endtask

    task automatic push_segment();
        int pick;
        int len;
        int n;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? FRAME_MAX : $urandom_range(2, FRAME_MAX);
        if (len == hdr_value)
            len = (len == FRAME_MAX) ? len - 1 : len + 1;
        if (pick < 55)
            push_frame(len, $urandom_range(0, 9) == 0, $urandom_range(0, 29) == 0);
        else if (pick < 68)
            repeat ($urandom_range(1, 3))
                push_rand(KIND_READ);
        else if (pick < 80)
            push_rand(KIND_RELEASE);
        else if (pick < 86)
        begin
            // partial frame left to go quiet
            push_byte(hdr_value);
            push_byte(len[7:0]);
            n = (tmo_limit >= 38) ? $urandom_range(1, 8) : tmo_limit + 1 + $urandom_range(0, 1);
            repeat (n)
                push_rand(KIND_TICK);
        end
        else if (pick < 92)
        begin
            push_byte(hdr_value);
            push_byte(($urandom_range(0, 1) == 1)
                      ? 8'($urandom_range(0, 1))
                      : 8'($urandom_range(FRAME_MAX + 1, 255)));
        end
        else if (pick < 96)
        begin
            // truncated frame, the next header restarts
            push_byte(hdr_value);
            push_byte(len[7:0]);
            repeat ($urandom_range(0, 3))
                push_byte(8'($urandom));
        end
        else
            repeat ($urandom_range(1, 4))
                push_rand(furs_kind_t'($urandom_range(0, 3)));
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEADER)
            hdr_value = val;
        else if (idx == CFG_TIMEOUT)
            tmo_limit = val;
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || s_tvalid || frame_result_q.size() != 0)
            @(posedge clk);
        repeat (6)
            @(posedge clk);
    endtask

    initial
    begin
        int         ph;
        int         start;
        logic [7:0] h;
        logic [7:0] l;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed opening with reset settings
        push_req(KIND_READ, 8'($urandom), 2'd0, 4'd0, 1'b0);
        push_req(KIND_RELEASE, 8'($urandom), 2'd2, 4'($urandom), 1'b0);
        push_byte(8'h3C);
        repeat (SLOTS)
        begin
            push_byte(hdr_value);
            push_byte(8'd3);
            push_byte(hdr_value + 8'd3);
        end
        push_byte(hdr_value);
        push_req(KIND_READ, 8'($urandom), 2'd2, 4'd2, 1'b0);
        push_req(KIND_READ, 8'($urandom), 2'd3, 4'd15, 1'b0);
        push_req(KIND_RELEASE, 8'($urandom), 2'd1, 4'($urandom), 1'b0);
        push_byte(hdr_value);
        push_req(KIND_RELEASE, 8'($urandom), 2'd0, 4'($urandom), 1'b0);
        push_byte(hdr_value);
        push_byte(8'd17);
        push_byte(hdr_value);
        push_byte(8'd0);
        push_byte(hdr_value);
        push_byte(8'd6);
        push_frame(3, 1'b0, 1'b0);
        push_frame(3, 1'b1, 1'b0);

        for (ph = 0; ph < 5; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    h = 8'h00;
                    l = 8'd0;
                end
                1:
                begin
                    h = 8'hFF;
                    l = 8'hFF;
                end
                2:
                begin
                    h = 8'($urandom);
                    l = 8'd3;
                end
                3:
                begin
                    h = HEADER_RST;
                    l = TIMEOUT_RST;
                end
                default:
                begin
                    h = 8'($urandom);
                    l = 8'($urandom_range(1, 20));
                end
            endcase
            write_reg(CFG_HEADER, h);
            write_reg(CFG_TIMEOUT, l);
            if (ph == 0)
            begin
                push_byte(hdr_value);
                push_byte(8'd4);
                push_rand(KIND_TICK);
            end
            start = total_queued;
            while (total_queued - start < 60)
                push_segment();
            if (ph == 1)
            begin
                // tick count runs into saturation and stays armed into the next setting
                push_byte(hdr_value);
                push_byte(8'd5);
                repeat (260)
                    push_rand(KIND_TICK);
            end
        end

        wait_drained();
        repeat (20)
            @(posedge clk);
        $display("Covered %0d requests, 6 settings, %0d good frames, %0d bad sums,",
                 accepted, n_good, n_bad);
        $display("%0d overlength, %0d timeouts, %0d byte reads, %0d full-ring drops",
                 n_overlen, n_timeout, n_read_hits, n_full_drops);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d failures", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/furs_pkg.sv
design/furs_store.sv
design/furs_ctrl.sv
design/framed_uart_receiver_slots_unit.sv
tb/framed_uart_receiver_slots_unit_test.sv
